// File: src/sic_pkg.sv
// shared types and constants for the stack integer calculator
package sic_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int STEP_W = $clog2(DATA_W);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] PAIR_CNT = CNT_W'(2);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_MUL   = 3'd3,
    OP_DIV   = 3'd4,
    OP_PRINT = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_FULL  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FETCH,
    S_RUN,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    STK_NONE,
    STK_PUSH,
    STK_REPLACE
  } stk_cmd_t;

  typedef struct packed {
    logic [2:0]               opcode;
    logic signed [DATA_W-1:0] push_value;
  } cmd_item_t;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] top_value;
    logic                     print_strobe;
  } rsp_item_t;

  typedef struct packed {
    stk_cmd_t          cmd;
    logic [DATA_W-1:0] data;
  } stk_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] tos;
    logic [DATA_W-1:0] second;
    logic [CNT_W-1:0]  count;
  } stk_view_t;

  typedef struct packed {
    logic              start;
    logic              is_div;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
  } md_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } md_rsp_t;

endpackage

// File: src/sic_stack.sv
// operand stack: top entry in a register, the rest in a memory with registered read
module sic_stack (
  input  logic              clk,
  input  logic              rst,
  input  sic_pkg::stk_req_t req,
  output sic_pkg::stk_view_t view
);
  import sic_pkg::*;

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] tos;
  logic [DATA_W-1:0] second;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  below;
  logic [CNT_W-1:0]  below2;

  assign below  = count - CNT_W'(1);
  assign below2 = count - CNT_W'(2);

  // memory holds entries under the top one, entry count-2 is the second operand
  always_ff @(posedge clk) begin
    if (req.cmd == STK_PUSH && count != '0) begin
      mem[below[ADDR_W-1:0]] <= tos;
    end
    second <= mem[below2[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (req.cmd)
        STK_PUSH:    count <= count + CNT_W'(1);
        STK_REPLACE: count <= below;
        default:     count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (req.cmd == STK_PUSH || req.cmd == STK_REPLACE) begin
      tos <= req.data;
    end
  end

  assign view.tos    = tos;
  assign view.second = second;
  assign view.count  = count;

endmodule

// File: src/sic_muldiv.sv
// iterative multiply and signed divide, one bit per cycle through one shared adder
module sic_muldiv (
  input  logic             clk,
  input  logic             rst,
  input  sic_pkg::md_req_t req,
  output sic_pkg::md_rsp_t rsp
);
  import sic_pkg::*;

  logic                busy;
  logic                done;
  logic                is_div;
  logic                neg;
  logic [STEP_W-1:0]   step;
  logic [DATA_W:0]     acc;
  logic [DATA_W-1:0]   opa;
  logic [DATA_W-1:0]   opb;
  logic [DATA_W:0]     add_a;
  logic [DATA_W:0]     add_b;
  logic [DATA_W+1:0]   sum;
  logic [DATA_W:0]     rem_sh;
  logic [DATA_W-1:0]   mag_x;
  logic [DATA_W-1:0]   mag_y;

  assign mag_x = req.x[DATA_W-1] ? (DATA_W'(0) - req.x) : req.x;
  assign mag_y = req.y[DATA_W-1] ? (DATA_W'(0) - req.y) : req.y;

  // divide: acc is the partial remainder, opb shifts the dividend out and quotient in
  assign rem_sh = {acc[DATA_W-1:0], opb[DATA_W-1]};

  always_comb begin
    if (is_div) begin
      add_a = rem_sh;
      add_b = ~{1'b0, opa};
    end else begin
      add_a = {1'b0, acc[DATA_W-1:0]};
      add_b = {1'b0, opa & {DATA_W{opb[0]}}};
    end
    sum = {1'b0, add_a} + {1'b0, add_b} + {{(DATA_W+1){1'b0}}, is_div};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      is_div <= req.is_div;
      neg    <= req.x[DATA_W-1] ^ req.y[DATA_W-1];
      acc    <= '0;
      if (req.is_div) begin
        opa <= mag_y;
        opb <= mag_x;
      end else begin
        opa <= req.x;
        opb <= req.y;
      end
    end else if (busy) begin
      if (is_div) begin
        // carry out set means no borrow: the divisor fits
        acc <= sum[DATA_W+1] ? sum[DATA_W:0] : rem_sh;
        opb <= {opb[DATA_W-2:0], sum[DATA_W+1]};
      end else begin
        acc <= sum[DATA_W:0];
        opa <= {opa[DATA_W-2:0], 1'b0};
        opb <= {1'b0, opb[DATA_W-1:1]};
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.result = !is_div ? acc[DATA_W-1:0] : (neg ? (DATA_W'(0) - opb) : opb);

endmodule

// File: src/stack_integer_calculator.sv
// push, print, unused opcodes, underflow and full stack: DECODE, FINISH
// add, subtract, divide by zero: DECODE, FETCH, FINISH; multiply and divide also RUN
// one word at a time; multiply and divide wait in RUN for the bit-serial unit
// a new command word is taken in the idle state while an earlier response may still wait
// reset (rst, synchronous) empties the stack and clears the response slot
// stack memory contents are not cleared; only entries below the count are used
module stack_integer_calculator (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  sic_pkg::cmd_item_t cmd,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output sic_pkg::rsp_item_t rsp
);
  import sic_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [2:0]        op;
  logic [DATA_W-1:0] val;
  status_t           status;
  status_t           status_next;
  logic              strobe;
  logic              strobe_next;
  logic              rsp_load;
  stk_req_t          stk_req;
  stk_view_t         stk;
  md_req_t           md_req;
  md_rsp_t           md_rsp;

  sic_stack u_stack (
    .clk  (clk),
    .rst  (rst),
    .req  (stk_req),
    .view (stk)
  );

  sic_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  assign cmd_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      status <= ST_OK;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      status <= status_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid) begin
      op  <= cmd.opcode;
      val <= cmd.push_value;
    end
  end

  always_comb begin
    state_next    = state;
    status_next   = status;
    strobe_next   = strobe;
    stk_req.cmd   = STK_NONE;
    stk_req.data  = val;
    md_req.start  = 1'b0;
    md_req.is_div = (op == OP_DIV);
    md_req.x      = stk.tos;
    md_req.y      = stk.second;
    rsp_load      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        status_next = ST_OK;
        strobe_next = 1'b0;
        state_next  = S_FINISH;
        unique case (op) inside
          OP_PUSH: begin
            if (stk.count >= FULL_CNT) begin
              status_next = ST_FULL;
            end else begin
              stk_req.cmd = STK_PUSH;
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (stk.count < PAIR_CNT) begin
              status_next = ST_UNDER;
            end else begin
              state_next = S_FETCH;
            end
          end
          OP_PRINT: begin
            if (stk.count == '0) begin
              status_next = ST_UNDER;
            end else begin
              strobe_next = 1'b1;
            end
          end
          default: begin
            status_next = ST_OK;
          end
        endcase
      end
      S_FETCH: begin
        state_next = S_FINISH;
        if (op == OP_DIV && stk.second == '0) begin
          status_next = ST_DIVZ;
        end else if (op == OP_ADD) begin
          stk_req.cmd  = STK_REPLACE;
          stk_req.data = stk.tos + stk.second;
        end else if (op == OP_SUB) begin
          stk_req.cmd  = STK_REPLACE;
          stk_req.data = stk.tos - stk.second;
        end else begin
          md_req.start = 1'b1;
          state_next   = S_RUN;
        end
      end
      S_RUN: begin
        if (md_rsp.done) begin
          stk_req.cmd  = STK_REPLACE;
          stk_req.data = md_rsp.result;
          state_next   = S_FINISH;
        end
      end
      S_FINISH: begin
        // wait for the response slot to be free
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.status       <= status;
      rsp.print_strobe <= strobe;
      rsp.top_value    <= (stk.count == '0) ? '0 : stk.tos;
    end
  end

endmodule
